FILE: rtl/tce_pkg.sv
// Shared types and constants of the threshold crossing edge unit.
// Used by every module of the block but tce_ram; depends on nothing else.
package tce_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 10;
    localparam int WID_W      = 11;
    localparam int MAX_WIDTH  = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd127;
    localparam logic [WID_W-1:0] WIDTH_RESET     = 11'd1024;
    localparam logic [ROW_W-1:0] HEIGHT_RESET    = 16'd1024;

    // The job queue depth must be a power of two so that its pointers wrap.
    localparam int JOB_DEPTH  = 4;
    localparam int JOB_PTR_W  = 2;
    localparam int JOB_CNT_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_UP,
        KIND_LEFT,
        KIND_FINAL
    } res_kind_t;

    typedef struct packed {
        logic [PIX_W-1:0] threshold;
        logic [WID_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
    } cfg_t;

    typedef struct packed {
        logic             has_up;
        logic [PIX_W-1:0] up_strength;
        logic             has_left;
        logic [PIX_W-1:0] left_strength;
        logic             has_final;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } job_t;

endpackage

FILE: rtl/threshold_crossing_edge_unit.sv
// Threshold crossing edge unit: line-store based edge strength on a pixel stream.
// Holds the configuration registers; depends on tce_pkg, tce_front, tce_job_fifo, tce_back.
//
// Pixels enter in raster order through push/full: a request is taken at a clock edge
// with push high and full low. Results leave through empty/pop: the oldest result sits
// on strength, out_row, out_col and run_last while empty is low, and is taken at an
// edge with pop high. Each result judges one position against its right and lower
// neighbours; run_last marks the last result that a pixel causes.
// A pixel's first result is registered in the s1 stage and then in the job queue before it
// appears on the ports, where the receiver can take it.
// Throughput is one pixel per cycle while full stays low, set by the single write and two
// reads of the line store per cycle; in a multi-row image every final-row pixel but the
// first gives two results, so the result port limits their rate, and the final pixel three.
// The first row of a multi-row image gives no result.
// A four-entry job queue parts the two sides: when the receiver stalls it fills and full
// rises until results are popped again. Reset clears the counters, sets threshold 127
// and a 1024 by 1024 image; the line store is not cleared and needs no time after reset.
// The user must write configuration through cfg_we, cfg_index and cfg_data only while the
// block is idle; the block itself does not enforce this.
module threshold_crossing_edge_unit
    import tce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIX_W-1:0]      strength,
    output logic [ROW_W-1:0]      out_row,
    output logic [COL_W-1:0]      out_col,
    output logic                  run_last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [PIX_W-1:0]     threshold_reg;
    logic [WID_W-1:0]     width_reg;
    logic [ROW_W-1:0]     height_reg;

    cfg_t                 cfg;
    job_t                 job;
    job_t                 head;
    logic                 job_push;
    logic                 job_pop;
    logic                 job_empty;
    logic [JOB_CNT_W-1:0] job_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:    threshold_reg <= cfg_data[PIX_W-1:0];
                REG_IMAGE_WIDTH:  width_reg     <= cfg_data[WID_W-1:0];
                REG_IMAGE_HEIGHT: height_reg    <= cfg_data[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    // A width of zero acts as one and a width beyond the line store acts as its size.
    always_comb
    begin
        cfg.threshold = threshold_reg;
        priority if (width_reg == '0)
            cfg.col_last = '0;
        else if (width_reg > WID_W'(MAX_WIDTH))
            cfg.col_last = WID_W'(MAX_WIDTH - 1);
        else
            cfg.col_last = width_reg - 1'b1;
        cfg.row_last = (height_reg == '0) ? '0 : height_reg - 1'b1;
    end

    tce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .cfg       (cfg),
        .job_count (job_count),
        .job_push  (job_push),
        .job       (job)
    );

    tce_job_fifo u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job),
        .pop       (job_pop),
        .head      (head),
        .empty     (job_empty),
        .count     (job_count)
    );

    tce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .strength  (strength),
        .out_row   (out_row),
        .out_col   (out_col),
        .run_last  (run_last)
    );

endmodule

FILE: rtl/tce_ram.sv
// Generic single-write, dual-read RAM with registered, read-first outputs.
// Stand-alone; no package needed.
module tce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

FILE: rtl/tce_front.sv
// Front part: pixel counters, line store access and judgement of each pixel.
// Depends on tce_pkg and tce_ram; produces at most one job per pixel for the queue.
module tce_front
    import tce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [PIX_W-1:0]     pixel,
    input  cfg_t                 cfg,
    input  logic [JOB_CNT_W-1:0] job_count,
    output logic                 job_push,
    output job_t                 job
);

    logic                 s1_valid_reg;
    logic [PIX_W-1:0]     s1_pixel_reg;
    logic [PIX_W-1:0]     s1_prev_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic                 s1_last_col_reg;
    logic                 s1_last_row_reg;

    logic [ROW_W-1:0]     row_count_reg, row_count_next;
    logic [COL_W-1:0]     col_count_reg, col_count_next;
    logic [PIX_W-1:0]     prev_pixel_reg;

    logic                 accept;
    logic                 last_col;
    logic                 last_row;
    logic [COL_W-1:0]     right_addr;
    logic [JOB_CNT_W:0]   inflight;
    logic [PIX_W-1:0]     centre_up;
    logic [PIX_W-1:0]     right_up;

    function automatic logic [PIX_W-1:0] judge(
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] r,
        input logic [PIX_W-1:0] d,
        input logic             has_r,
        input logic             has_d,
        input logic [PIX_W-1:0] t
    );
        logic [PIX_W-1:0] ch;
        logic [PIX_W-1:0] res;
        res = '0;
        if (c <= t)
        begin
            if (has_r && has_d)
                ch = (d > r) ? d : r;
            else
                ch = has_d ? d : r;
            if (ch > t)
                res = ch - c;
        end
        else
        begin
            if (has_r && has_d)
                ch = (d < r) ? d : r;
            else
                ch = has_d ? d : r;
            if (ch <= t)
                res = c - ch;
        end
        if (!has_r && !has_d)
            res = '0;
        return res;
    endfunction

    always_comb
    begin
        inflight   = {1'b0, job_count} + {{JOB_CNT_W{1'b0}}, s1_valid_reg};
        full       = inflight >= (JOB_CNT_W+1)'(JOB_DEPTH);
        accept     = push && !full;
        last_col   = {1'b0, col_count_reg} >= cfg.col_last;
        last_row   = row_count_reg >= cfg.row_last;
        right_addr = col_count_reg + 1'b1;

        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : row_count_reg + 1'b1;
            end
            else
            begin
                col_count_next = col_count_reg + 1'b1;
            end
        end
    end

    tce_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .we      (accept),
        .waddr   (col_count_reg),
        .wdata   (pixel),
        .re      (accept),
        .raddr_a (col_count_reg),
        .raddr_b (right_addr),
        .rdata_a (centre_up),
        .rdata_b (right_up)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            prev_pixel_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            if (accept)
                prev_pixel_reg <= pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg    <= pixel;
            s1_prev_reg     <= prev_pixel_reg;
            s1_row_reg      <= row_count_reg;
            s1_col_reg      <= col_count_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    always_comb
    begin
        job.has_up        = s1_row_reg != '0;
        job.up_strength   = judge(centre_up, right_up, s1_pixel_reg, !s1_last_col_reg,
                                  1'b1, cfg.threshold);
        job.has_left      = s1_last_row_reg && (s1_col_reg != '0);
        job.left_strength = judge(s1_prev_reg, s1_pixel_reg, '0, 1'b1, 1'b0,
                                  cfg.threshold);
        job.has_final     = s1_last_row_reg && s1_last_col_reg;
        job.row           = s1_row_reg;
        job.col           = s1_col_reg;
        job_push          = s1_valid_reg && (job.has_up || job.has_left || job.has_final);
    end

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        inflight <= (JOB_CNT_W+1)'(JOB_DEPTH))
        else $error("Job queue credit exceeded.");

    a_image_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_col && last_row |=> row_count_reg == '0 && col_count_reg == '0)
        else $error("Counters did not return to zero after the final pixel.");

endmodule

FILE: rtl/tce_job_fifo.sv
// Short queue of jobs between the front and the back part.
// Depends on tce_pkg for the job type and the queue depth.
module tce_job_fifo
    import tce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  job_t                 push_data,
    input  logic                 pop,
    output job_t                 head,
    output logic                 empty,
    output logic [JOB_CNT_W-1:0] count
);

    job_t                 store_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{(JOB_CNT_W-1){1'b0}}, push}
                                - {{(JOB_CNT_W-1){1'b0}}, pop};
        empty       = count_reg == '0;
        count       = count_reg;
        head        = store_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg < JOB_CNT_W'(JOB_DEPTH))
        else $error("Job pushed into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("Job popped from an empty queue.");

endmodule

FILE: rtl/tce_back.sv
// Back part: expands each queued job into its one to three result requests.
// Depends on tce_pkg; reads the head of the job queue and drives the result ports.
module tce_back
    import tce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  job_t             head,
    input  logic             job_empty,
    output logic             job_pop,
    input  logic             pop,
    output logic             empty,
    output logic [PIX_W-1:0] strength,
    output logic [ROW_W-1:0] out_row,
    output logic [COL_W-1:0] out_col,
    output logic             run_last
);

    logic      done_up_reg, done_up_next;
    logic      done_left_reg, done_left_next;
    res_kind_t kind;
    logic      take;

    always_comb
    begin
        priority if (head.has_up && !done_up_reg)
            kind = KIND_UP;
        else if (head.has_left && !done_left_reg)
            kind = KIND_LEFT;
        else
            kind = KIND_FINAL;

        unique case (kind)
            KIND_UP:
            begin
                strength = head.up_strength;
                out_row  = head.row - 1'b1;
                out_col  = head.col;
                run_last = !head.has_left && !head.has_final;
            end
            KIND_LEFT:
            begin
                strength = head.left_strength;
                out_row  = head.row;
                out_col  = head.col - 1'b1;
                run_last = !head.has_final;
            end
            default:
            begin
                strength = '0;
                out_row  = head.row;
                out_col  = head.col;
                run_last = 1'b1;
            end
        endcase

        empty   = job_empty;
        take    = pop && !job_empty;
        job_pop = take && run_last;

        done_up_next   = done_up_reg;
        done_left_next = done_left_reg;
        if (take)
        begin
            if (run_last)
            begin
                done_up_next   = 1'b0;
                done_left_next = 1'b0;
            end
            else if (kind == KIND_UP)
            begin
                done_up_next = 1'b1;
            end
            else
            begin
                done_left_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_up_reg   <= 1'b0;
            done_left_reg <= 1'b0;
        end
        else
        begin
            done_up_reg   <= done_up_next;
            done_left_reg <= done_left_next;
        end
    end

    a_job_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !job_empty |-> (head.has_up || head.has_left || head.has_final))
        else $error("Queued job carries no result.");

    a_final_exists: assert property (@(posedge clk) disable iff (!rst_n)
        !job_empty && kind == KIND_FINAL |-> head.has_final)
        else $error("Final result selected for a job without one.");

endmodule

FILE: tb/tb_threshold_crossing_edge_unit.sv
// Self-checking testbench of the threshold crossing edge unit: a scoreboard predicts every
// edge result from the accepted pixel requests and compares it with what the block returns.
// Depends on tce_pkg and threshold_crossing_edge_unit.

class edge_scoreboard;

    typedef struct {
        logic [tce_pkg::PIX_W-1:0] strength;
        logic [tce_pkg::ROW_W-1:0] row;
        logic [tce_pkg::COL_W-1:0] col;
        logic                      last;
    } edge_result_t;

    logic [tce_pkg::PIX_W-1:0] threshold;
    logic [tce_pkg::WID_W-1:0] width_reg;
    logic [tce_pkg::ROW_W-1:0] height_reg;
    logic [tce_pkg::PIX_W-1:0] line_mem [tce_pkg::MAX_WIDTH];
    logic [tce_pkg::ROW_W-1:0] row_cnt;
    logic [tce_pkg::COL_W-1:0] col_cnt;
    logic [tce_pkg::PIX_W-1:0] prev_pix;
    edge_result_t              expected_edges [$];
    int                        failures;

    function new();
        threshold  = tce_pkg::THRESHOLD_RESET;
        width_reg  = tce_pkg::WIDTH_RESET;
        height_reg = tce_pkg::HEIGHT_RESET;
        row_cnt    = '0;
        col_cnt    = '0;
        prev_pix   = '0;
        failures   = 0;
        foreach (line_mem[i])
        begin
            line_mem[i] = '0;
        end
    endfunction

    function void write_reg(tce_pkg::cfg_reg_t idx, logic [tce_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            tce_pkg::REG_THRESHOLD:    threshold  = val[tce_pkg::PIX_W-1:0];
            tce_pkg::REG_IMAGE_WIDTH:  width_reg  = val[tce_pkg::WID_W-1:0];
            tce_pkg::REG_IMAGE_HEIGHT: height_reg = val[tce_pkg::ROW_W-1:0];
            default: ;
        endcase
    endfunction

    function int eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > tce_pkg::MAX_WIDTH)
            return tce_pkg::MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function int eff_height();
        if (height_reg == 0)
            return 1;
        return int'(height_reg);
    endfunction

    function int pixels_left_in_image();
        int w;
        int h;
        int rem;
        w = eff_width();
        h = eff_height();
        rem = (int'(col_cnt) >= w - 1) ? 1 : w - int'(col_cnt);
        if (int'(row_cnt) >= h - 1)
            return rem;
        return rem + (h - 1 - int'(row_cnt)) * w;
    endfunction

    function int crossing_strength(int centre, int right, int lower, bit has_right,
                                   bit has_lower);
        int t;
        int pick;
        t = int'(threshold);
        if (!has_right && !has_lower)
            return 0;
        if (centre <= t)
        begin
            if (has_right && has_lower)
                pick = (lower > right) ? lower : right;
            else
                pick = has_lower ? lower : right;
            return (pick > t) ? pick - centre : 0;
        end
        if (has_right && has_lower)
            pick = (lower < right) ? lower : right;
        else
            pick = has_lower ? lower : right;
        return (pick <= t) ? centre - pick : 0;
    endfunction

    function void add_expected(int s, int row, int col);
        edge_result_t e;
        e.strength = s[tce_pkg::PIX_W-1:0];
        e.row      = row[tce_pkg::ROW_W-1:0];
        e.col      = col[tce_pkg::COL_W-1:0];
        e.last     = 1'b0;
        expected_edges.push_back(e);
    endfunction

    function void accept_pixel(logic [tce_pkg::PIX_W-1:0] p);
        int w;
        int h;
        int col;
        int row;
        int right;
        int first;
        bit last_col;
        bit last_row;
        w = eff_width();
        h = eff_height();
        col = int'(col_cnt);
        row = int'(row_cnt);
        last_col = (col >= w - 1);
        last_row = (row >= h - 1);
        first = expected_edges.size();
        if (row > 0)
        begin
            right = last_col ? 0 : int'(line_mem[col + 1]);
            add_expected(crossing_strength(int'(line_mem[col]), right, int'(p), !last_col, 1'b1),
                         row - 1, col);
        end
        if (last_row && col > 0)
            add_expected(crossing_strength(int'(prev_pix), int'(p), 0, 1'b1, 1'b0), row, col - 1);
        if (last_row && last_col)
            add_expected(0, row, col);
        if (expected_edges.size() > first)
            expected_edges[expected_edges.size() - 1].last = 1'b1;
        line_mem[col] = p;
        prev_pix = p;
        if (last_col)
        begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : row_cnt + 1'b1;
        end
        else
        begin
            col_cnt = col_cnt + 1'b1;
        end
    endfunction

    function void check_edge(logic [tce_pkg::PIX_W-1:0] s, logic [tce_pkg::ROW_W-1:0] row,
                             logic [tce_pkg::COL_W-1:0] col, logic last);
        edge_result_t e;
        if (expected_edges.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("Unexpected result: strength %0d row %0d col %0d last %0b",
                         s, row, col, last);
            return;
        end
        e = expected_edges.pop_front();
        if (s !== e.strength || row !== e.row || col !== e.col || last !== e.last)
        begin
            failures++;
            if (failures <= 10)
                $display("Mismatch: expected strength %0d row %0d col %0d last %0b, %s %0d %s",
                         e.strength, e.row, e.col, e.last, "got strength", s,
                         $sformatf("row %0d col %0d last %0b", row, col, last));
        end
    endfunction

endclass

module tb_threshold_crossing_edge_unit;
    import tce_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 340;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic [PIX_W-1:0]      pixel     = '0;
    logic                  pop       = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  full;
    logic                  empty;
    logic [PIX_W-1:0]      strength;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  run_last;

    edge_scoreboard sb;
    bit             push_idling  = 1'b0;
    bit             pop_idling   = 1'b0;
    int             pop_stall    = 0;
    int             quiet_cycles = 0;

    threshold_crossing_edge_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .strength  (strength),
        .out_row   (out_row),
        .out_col   (out_col),
        .run_last  (run_last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int gap_length(bit idling);
        int r;
        r = $urandom_range(0, 99);
        if (!idling || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        if (r < 20)
            return 16'd255;
        if (r < 30)
            return 16'd127 + 16'($urandom_range(0, 1));
        return 16'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 16'd0;
        if (r < 15)
            return 16'd1;
        if (r < 70)
            return 16'($urandom_range(2, 8));
        if (r < 93)
            return 16'($urandom_range(9, 40));
        if (r < 97)
            return 16'd1024;
        return 16'($urandom_range(1025, 2047));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 16'd0;
        if (r < 15)
            return 16'd1;
        if (r < 75)
            return 16'($urandom_range(2, 6));
        if (r < 93)
            return 16'($urandom_range(7, 40));
        return 16'd65535;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(logic [PIX_W-1:0] thr);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'd0;
        if (r < 16)
            return 8'd255;
        if (r < 30)
            return thr;
        if (r < 44)
            return thr + 8'd1;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] p);
        int gap;
        gap = gap_length(push_idling);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.accept_pixel(p);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (sb.expected_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_image(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] wid,
                             input logic [CFG_DATA_W-1:0] hgt);
        settle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_IMAGE_WIDTH, wid);
        write_reg(REG_IMAGE_HEIGHT, hgt);
        cfg_we <= 1'b0;
    endtask

    task automatic send_list(input logic [PIX_W-1:0] pix [$]);
        foreach (pix[i])
        begin
            send_pixel(pix[i]);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                sb.check_edge(strength, out_row, out_col, run_last);
                pop_stall = gap_length(pop_idling);
            end
            if (pop_stall > 0)
            begin
                pop <= 1'b0;
                pop_stall--;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("[threshold_crossing_edge_unit] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [PIX_W-1:0] img_a [$];
        int               count;
        int               random_sent;
        sb = new();
        random_sent = 0;
        img_a = '{8'd127, 8'd128, 8'd0, 8'd255, 8'd128, 8'd127, 8'd255, 8'd0,
                  8'd255, 8'd0, 8'd127, 8'd128};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_image(16'd127, 16'd4, 16'd3);
        foreach (img_a[i])
        begin
            if (i == 6)
                settle();
            send_pixel(img_a[i]);
        end
        set_image(16'd255, 16'd1, 16'd2);
        send_list('{8'd255, 8'd0});
        set_image(16'd0, 16'd1, 16'd1);
        send_list('{8'd200});
        set_image(16'd0, 16'd0, 16'd0);
        send_list('{8'd0});
        set_image(16'd0, 16'd2, 16'd2);
        send_list('{8'd0, 8'd1, 8'd1, 8'd0});

        while (random_sent < RANDOM_PIXELS)
        begin
            push_idling = ($urandom_range(0, 3) != 0);
            pop_idling  = ($urandom_range(0, 3) != 0);
            settle();
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_THRESHOLD, pick_threshold());
            // The width changes only in the first row of an image, so every line store
            // entry that a later row reads has been written before.
            if (sb.row_cnt == '0 && $urandom_range(0, 2) != 0)
                write_reg(REG_IMAGE_WIDTH, pick_width());
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_IMAGE_HEIGHT, pick_height());
            cfg_we <= 1'b0;
            count = sb.pixels_left_in_image();
            if (count > 200 || $urandom_range(0, 9) < 2)
                count = $urandom_range(1, 30);
            if (count > RANDOM_PIXELS - random_sent)
                count = RANDOM_PIXELS - random_sent;
            repeat (count)
            begin
                if ($urandom_range(0, 49) == 0)
                    settle();
                send_pixel(pick_pixel(sb.threshold));
            end
            random_sent += count;
        end

        settle();
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.expected_edges.size() == 0)
            $display("[threshold_crossing_edge_unit] OK");
        else
            $display("[threshold_crossing_edge_unit] ERROR");
        $finish;
    end

endmodule
